// ===== sv/fir_decimator_by_two_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the decimating FIR filter
// Immediate-consequence and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef FIR_DECIMATOR_BY_TWO_MACROS_SVH
`define FIR_DECIMATOR_BY_TWO_MACROS_SVH

`ifndef SYNTHESIS
`define FDB_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define FDB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FDB_ASSERT_IMPLY(label, ante, cons, msg)
`define FDB_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/fdb_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimating FIR package
// Coefficient table, fixed-point constants and the controller state type.
// ----------------------------------------------------------------------------
package fdb_pkg;

	localparam int COEF_BITS = 16;
	localparam int FRAC_BITS = 15;
	localparam int BASE_TAPS = 32;
	localparam int BASE_IDX_W = 5;

	typedef logic signed [COEF_BITS-1:0] coef_t;

	localparam coef_t BASE_COEFS [BASE_TAPS] = '{
		-16'sd476, -16'sd509, 16'sd546, 16'sd590, -16'sd641, -16'sd702, 16'sd776, 16'sd868,
		-16'sd983, -16'sd1135, 16'sd1341, 16'sd1639, -16'sd2107, -16'sd2950, 16'sd4917,
		16'sd14751, 16'sd14751, 16'sd4917, -16'sd2950, -16'sd2107, 16'sd1639, 16'sd1341,
		-16'sd1135, -16'sd983, 16'sd868, 16'sd776, -16'sd702, -16'sd641, 16'sd590, 16'sd546,
		-16'sd509, -16'sd476
	};

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MAC   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} fdb_state_t;

endpackage

// ===== sv/fdb_sample_if.sv =====
// ----------------------------------------------------------------------------
// Input sample channel
// Valid/ready stream that carries one signed sample per beat.
// ----------------------------------------------------------------------------
interface fdb_sample_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ===== sv/fdb_result_if.sv =====
// ----------------------------------------------------------------------------
// Filtered output channel
// Valid/ready stream that carries one decimated filter output per beat.
// ----------------------------------------------------------------------------
interface fdb_result_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] filtered_sample;

	modport source (output valid, output filtered_sample, input ready);
	modport sink (input valid, input filtered_sample, output ready);
endinterface

// ===== sv/fir_decimator_by_two.sv =====
// ----------------------------------------------------------------------------
// FIR low-pass decimator by two
// Delay line in a circular single-port-read memory, one shared multiply-add.
// ----------------------------------------------------------------------------
// Every input beat writes one sample into the delay-line memory.
// Odd-numbered beats end there and produce nothing. Even-numbered beats (the
// first after reset included) then read the TAPS newest samples one per cycle
// through the memory read port into a pipelined multiply-accumulate; the block
// takes no new sample until that pass has drained and its result is in the
// output register. The finished output sits in that register, so new samples
// are taken while it waits on the sink. Entries not yet written read as zero
// through a fill count; the stream tail is flushed by feeding zero samples.
`include "fir_decimator_by_two_macros.svh"

module fir_decimator_by_two
	import fdb_pkg::*;
#(
	parameter int TAPS        = 32,
	parameter int SAMPLE_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	fdb_sample_if.sink   samples,
	fdb_result_if.source results
);

	localparam int AW     = $clog2(TAPS);
	localparam int CW0    = $clog2(TAPS + 1);
	localparam int JW     = (CW0 > BASE_IDX_W) ? CW0 : BASE_IDX_W;
	localparam int PW     = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W  = PW + AW + 1;

	localparam logic [AW-1:0]   LAST_ADDR = AW'(TAPS - 1);
	localparam logic [JW-1:0]   LAST_TAP  = JW'(TAPS - 1);
	localparam logic [JW-1:0]   FULL      = JW'(TAPS);
	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI   = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);

	logic [SAMPLE_BITS-1:0] mem [TAPS];

	fdb_state_t state_q;
	logic                  phase_q;
	logic [AW-1:0]         wp_q;
	logic [AW-1:0]         rp_q;
	logic [JW-1:0]         j_q;
	logic [JW-1:0]         fill_q;

	logic                          v_s1;
	logic                          ok_s1;
	logic signed [SAMPLE_BITS-1:0] rd_s1;
	coef_t                         coef_s1;
	logic                          v_s2;
	logic signed [PW-1:0]          prod_s2;
	logic signed [ACC_W-1:0]       acc_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;

	logic                    in_beat;
	logic                    issue;
	logic                    out_free;
	logic signed [ACC_W-1:0] rounded;
	logic signed [ACC_W-1:0] clamped;

	assign samples.ready           = (state_q == ST_IDLE);
	assign in_beat                 = samples.valid && samples.ready;
	assign issue                   = (state_q == ST_MAC);
	assign out_free                = !out_valid_q || results.ready;
	assign results.valid           = out_valid_q;
	assign results.filtered_sample = out_data_q;

	always_comb begin
		rounded = (acc_q + HALF_LSB) >>> FRAC_BITS;
		if (rounded > SAT_HI) begin
			clamped = SAT_HI;
		end else if (rounded < SAT_LO) begin
			clamped = SAT_LO;
		end else begin
			clamped = rounded;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			mem[wp_q] <= samples.sample;
		end
		if (issue) begin
			rd_s1 <= mem[rp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			coef_s1 <= (j_q < BASE_TAPS) ? BASE_COEFS[j_q[BASE_IDX_W-1:0]] : '0;
			ok_s1   <= (j_q < fill_q);
		end
		if (v_s1) begin
			if (ok_s1) begin
				prod_s2 <= rd_s1 * coef_s1;
			end else begin
				prod_s2 <= '0;
			end
		end
		if (state_q == ST_EMIT && out_free) begin
			out_data_q <= clamped[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			wp_q        <= '0;
			rp_q        <= '0;
			j_q         <= '0;
			fill_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (v_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						wp_q    <= (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
						fill_q  <= (fill_q == FULL) ? fill_q : fill_q + JW'(1);
						phase_q <= !phase_q;
						if (!phase_q) begin
							rp_q    <= wp_q;
							j_q     <= '0;
							acc_q   <= '0;
							state_q <= ST_MAC;
						end
					end
				end
				ST_MAC: begin
					rp_q <= (rp_q == '0) ? LAST_ADDR : rp_q - AW'(1);
					j_q  <= j_q + JW'(1);
					if (j_q == LAST_TAP) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`FDB_ASSERT_IMPLY(a_emit_after_drain, state_q == ST_EMIT, !v_s1 && !v_s2,
		"Output formed while the multiply-accumulate pipeline still holds taps.")
	`FDB_ASSERT_IMPLY(a_fill_bound, 1'b1, fill_q <= FULL,
		"Fill count ran past the delay-line length.")
	`FDB_ASSERT_NEXT(a_even_starts_mac, in_beat && !phase_q, state_q == ST_MAC,
		"An even-numbered beat did not start a filter pass.")
	`FDB_ASSERT_IMPLY(a_valid_from_emit, $rose(out_valid_q), $past(state_q == ST_EMIT),
		"Output became valid without a finished filter pass.")

endmodule
